/* design/bptc_pkg.sv */
package bptc_pkg;

	// Register map of the calibration port
	typedef enum logic [2:0] {
		REG_PRESSURE_SENSITIVITY   = 3'd0,
		REG_PRESSURE_OFFSET        = 3'd1,
		REG_SENSITIVITY_TEMP_COEFF = 3'd2,
		REG_OFFSET_TEMP_COEFF      = 3'd3,
		REG_REFERENCE_TEMPERATURE  = 3'd4,
		REG_TEMPERATURE_COEFF      = 3'd5
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Temperature thresholds in hundredths of a degree
	localparam int TEMP_BASE = 2000;
	localparam int TEMP_LOW  = 1500;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_coeff;
	} cfg_t;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_word_t;

	typedef struct packed {
		logic signed [18:0] temperature_centi;
		logic signed [31:0] pressure_out;
		logic               pressure_saturated;
	} out_word_t;

	// First-order results handed to the second-order correction
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [18:0] temp;
		logic signed [35:0] off;
		logic signed [35:0] sens;
		logic [17:0]        t2;
	} first_t;

	// Fully corrected terms handed to the pressure stage
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [18:0] temp;
		logic signed [39:0] off;
		logic signed [39:0] sens;
	} second_t;

endpackage

/* design/bptc_cfg.sv */
module bptc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bptc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bptc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output bptc_pkg::cfg_t                   cfg
);
	import bptc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PRESSURE_SENSITIVITY:   cfg_q.pressure_sensitivity   <= cfg_wdata;
				REG_PRESSURE_OFFSET:        cfg_q.pressure_offset        <= cfg_wdata;
				REG_SENSITIVITY_TEMP_COEFF: cfg_q.sensitivity_temp_coeff <= cfg_wdata;
				REG_OFFSET_TEMP_COEFF:      cfg_q.offset_temp_coeff      <= cfg_wdata;
				REG_REFERENCE_TEMPERATURE:  cfg_q.reference_temperature  <= cfg_wdata;
				REG_TEMPERATURE_COEFF:      cfg_q.temperature_coeff      <= cfg_wdata;
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/bptc_first.sv */
module bptc_first (
	input  logic               clk,
	input  logic               arst_n,
	input  bptc_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  bptc_pkg::in_word_t in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output bptc_pkg::first_t   out_data
);
	import bptc_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [23:0]        d1_s1, d1_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] prod_temp_s2, prod_off_s2, prod_sens_s2;
	logic signed [49:0] dt_sq_s2;
	first_t             data_s3;

	logic [24:0]        dt_w;
	logic [19:0]        temp_w;
	logic [35:0]        off_w, sens_w;

	// A stage moves when it is empty or the next one moves
	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	assign dt_w = {1'b0, in_word.raw_temperature} - {1'b0, cfg.reference_temperature, 8'h00};

	always_comb begin
		temp_w = {prod_temp_s2[41], prod_temp_s2[41:23]} + 20'(TEMP_BASE);
		off_w  = {4'h0, cfg.pressure_offset, 16'h0000}
		       + {prod_off_s2[41], prod_off_s2[41:7]};
		sens_w = {5'h00, cfg.pressure_sensitivity, 15'h0000}
		       + {{2{prod_sens_s2[41]}}, prod_sens_s2[41:8]};
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			d1_s1 <= in_word.raw_pressure;
			dt_s1 <= $signed(dt_w);
		end
		if (adv_s2 && valid_s1) begin
			d1_s2        <= d1_s1;
			prod_temp_s2 <= dt_s1 * $signed({1'b0, cfg.temperature_coeff});
			prod_off_s2  <= dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
			prod_sens_s2 <= dt_s1 * $signed({1'b0, cfg.sensitivity_temp_coeff});
			dt_sq_s2     <= dt_s1 * dt_s1;
		end
		if (adv_s3 && valid_s2) begin
			data_s3.d1   <= d1_s2;
			data_s3.temp <= $signed(temp_w[18:0]);
			data_s3.off  <= $signed(off_w);
			data_s3.sens <= $signed(sens_w);
			data_s3.t2   <= dt_sq_s2[48:31];
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* design/bptc_second.sv */
module bptc_second (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bptc_pkg::first_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bptc_pkg::second_t out_data
);
	import bptc_pkg::*;

	logic valid_s4, valid_s5, valid_s6;
	logic adv_s4, adv_s5, adv_s6;

	first_t             carry_s4;
	logic [35:0]        sq_s4, sq2_s4;
	logic               cold_s4, very_cold_s4;

	logic [23:0]        d1_s5;
	logic signed [18:0] temp_s5;
	logic signed [35:0] off_s5, sens_s5;
	logic [39:0]        off2_s5, sens2_s5;

	second_t            data_s6;

	logic signed [19:0] a_w, b_w;
	logic signed [39:0] sq_full_w, sq2_full_w;
	logic [38:0]        five_w, seven_w;
	logic [39:0]        eleven_w;
	logic [39:0]        off2_w, sens2_w;
	logic [19:0]        temp_w;

	assign adv_s6   = !valid_s6 || !out_stall;
	assign adv_s5   = !valid_s5 || adv_s6;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign in_stall = !adv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv_s4) valid_s4 <= in_valid;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		a_w        = {in_data.temp[18], in_data.temp} - 20'(TEMP_BASE);
		b_w        = {in_data.temp[18], in_data.temp} + 20'(TEMP_LOW);
		sq_full_w  = a_w * a_w;
		sq2_full_w = b_w * b_w;
	end

	// Constant multiples by shifts, adds and a subtract, each term floored on its own
	always_comb begin
		five_w   = {1'b0, sq_s4, 2'b00} + {3'b000, sq_s4};
		seven_w  = {sq2_s4, 3'b000} - {3'b000, sq2_s4};
		eleven_w = {1'b0, sq2_s4, 3'b000} + {3'b000, sq2_s4, 1'b0} + {4'h0, sq2_s4};
		off2_w   = '0;
		sens2_w  = '0;
		temp_w   = {carry_s4.temp[18], carry_s4.temp};
		if (cold_s4) begin
			off2_w  = {2'b00, five_w[38:1]};
			sens2_w = {3'b000, five_w[38:2]};
			temp_w  = {carry_s4.temp[18], carry_s4.temp} - {2'b00, carry_s4.t2};
			if (very_cold_s4) begin
				off2_w  = off2_w + {1'b0, seven_w};
				sens2_w = sens2_w + {1'b0, eleven_w[39:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && in_valid) begin
			carry_s4     <= in_data;
			sq_s4        <= sq_full_w[35:0];
			sq2_s4       <= sq2_full_w[35:0];
			cold_s4      <= a_w[19];
			very_cold_s4 <= b_w[19];
		end
		if (adv_s5 && valid_s4) begin
			d1_s5    <= carry_s4.d1;
			temp_s5  <= $signed(temp_w[18:0]);
			off_s5   <= carry_s4.off;
			sens_s5  <= carry_s4.sens;
			off2_s5  <= off2_w;
			sens2_s5 <= sens2_w;
		end
		if (adv_s6 && valid_s5) begin
			data_s6.d1   <= d1_s5;
			data_s6.temp <= temp_s5;
			data_s6.off  <= $signed({{4{off_s5[35]}}, off_s5} - off2_s5);
			data_s6.sens <= $signed({{4{sens_s5[35]}}, sens_s5} - sens2_s5);
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = data_s6;

endmodule

/* design/bptc_press.sv */
module bptc_press (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bptc_pkg::second_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bptc_pkg::out_word_t out_word
);
	import bptc_pkg::*;

	logic valid_s7, valid_s8, valid_s9;
	logic adv_s7, adv_s8, adv_s9;

	logic [43:0]        prod_lo_s7;
	logic signed [44:0] prod_hi_s7;
	logic signed [39:0] off_s7, off_s8;
	logic signed [18:0] temp_s7, temp_s8;
	logic [42:0]        scaled_s8;
	out_word_t          word_s9;

	logic [63:0]        sum_w;
	logic [47:0]        diff_w;
	logic [32:0]        p_w;

	assign adv_s9   = !valid_s9 || !out_stall;
	assign adv_s8   = !valid_s8 || adv_s9;
	assign adv_s7   = !valid_s7 || adv_s8;
	assign in_stall = !adv_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (adv_s7) valid_s7 <= in_valid;
			if (adv_s8) valid_s8 <= valid_s7;
			if (adv_s9) valid_s9 <= valid_s8;
		end
	end

	always_comb begin
		// Recombine the split product of raw pressure and sensitivity
		sum_w  = 64'({prod_hi_s7, 20'h00000}) + {20'h00000, prod_lo_s7};
		diff_w = {{5{scaled_s8[42]}}, scaled_s8} - {{8{off_s8[39]}}, off_s8};
		p_w    = diff_w[47:15];
	end

	always_ff @(posedge clk) begin
		if (adv_s7 && in_valid) begin
			prod_lo_s7 <= in_data.d1 * in_data.sens[19:0];
			prod_hi_s7 <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);
			off_s7     <= in_data.off;
			temp_s7    <= in_data.temp;
		end
		if (adv_s8 && valid_s7) begin
			scaled_s8 <= sum_w[63:21];
			off_s8    <= off_s7;
			temp_s8   <= temp_s7;
		end
		if (adv_s9 && valid_s8) begin
			word_s9.temperature_centi <= temp_s8;
			// Clamp when the top two bits disagree
			case (p_w[32:31])
				2'b01: begin
					word_s9.pressure_out       <= 32'sh7FFF_FFFF;
					word_s9.pressure_saturated <= 1'b1;
				end
				2'b10: begin
					word_s9.pressure_out       <= 32'sh8000_0000;
					word_s9.pressure_saturated <= 1'b1;
				end
				default: begin
					word_s9.pressure_out       <= $signed(p_w[31:0]);
					word_s9.pressure_saturated <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = valid_s9;
	assign out_word  = word_s9;

endmodule

/* design/baro_pressure_temp_compensation_top.sv */
// Barometric sensor compensation: each input word carries one raw pressure and one raw
// temperature conversion; each output word gives the temperature in 0.01 C, the pressure
// in Pa clamped to signed 32 bits, and a flag set when it was clamped. Second-order
// corrections apply below 20.00 C, with an extra term below -15.00 C. The pipeline has
// nine register stages and takes one word every clock while in_stall is low. The stages
// hold the multipliers: coefficient products, squares, and the raw pressure times
// sensitivity product split into two partial products. Bubbles fill in while the output
// is stalled. Calibration words must be written through the register port only while
// no word is in flight; the block does not enforce it. All six reset to zero.
module baro_pressure_temp_compensation_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bptc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bptc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bptc_pkg::in_word_t               in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bptc_pkg::out_word_t              out_word
);
	import bptc_pkg::*;

	cfg_t    cfg;
	first_t  first_data;
	second_t second_data;
	logic    first_valid, first_stall;
	logic    second_valid, second_stall;

	bptc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bptc_first u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (first_valid),
		.out_stall (first_stall),
		.out_data  (first_data)
	);

	bptc_second u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (first_valid),
		.in_stall  (first_stall),
		.in_data   (first_data),
		.out_valid (second_valid),
		.out_stall (second_stall),
		.out_data  (second_data)
	);

	bptc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (second_valid),
		.in_stall  (second_stall),
		.in_data   (second_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
